/* design/lccc_pkg.sv */
// ----------------------------------------------------------------------------
// lccc_pkg
// Shared types and constants for the lidar cluster circle-center block.
// ----------------------------------------------------------------------------
package lccc_pkg;

	localparam int CoordW = 16;
	localparam int CenterW = 24;
	localparam int GapW = 15;
	localparam int MinW = 11;
	localparam int CfgAddrW = 2;
	localparam int CfgDataW = 15;

	localparam logic [CfgAddrW-1:0] REG_CLUSTER_GAP = 2'd0;
	localparam logic [CfgAddrW-1:0] REG_MIN_POINTS = 2'd1;
	localparam logic [CfgAddrW-1:0] REG_DEPTH_LIMIT = 2'd2;

	localparam logic signed [CenterW-1:0] CenterMax = 24'sh7FFFFF;
	localparam logic signed [CenterW-1:0] CenterMin = -24'sh800000;

	typedef struct packed {
		logic signed [CoordW-1:0] y;
		logic signed [CoordW-1:0] x;
	} point_t;

	typedef struct packed {
		logic signed [CoordW-1:0] point_x;
		logic signed [CoordW-1:0] point_y;
		logic                     scan_end;
	} in_word_t;

	typedef struct packed {
		logic signed [CenterW-1:0] center_x;
		logic signed [CenterW-1:0] center_y;
	} out_word_t;

	// fit request from segmenter to fitter
	typedef struct packed {
		logic start;
		logic busy;
	} fit_ctl_t;

endpackage

/* design/lccc_if.sv */
// ----------------------------------------------------------------------------
// lccc_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface lccc_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* design/lccc_ram.sv */
// ----------------------------------------------------------------------------
// lccc_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module lccc_ram #(
	parameter int Width = 32,
	parameter int Depth = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

/* design/lccc_div.sv */
// ----------------------------------------------------------------------------
// lccc_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lccc_div #(
	parameter int NumW = 72,
	parameter int DenW = 40
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NumW-1:0] num,
	input  logic [DenW-1:0] den,
	output logic            done,
	output logic [NumW-1:0] quo
);
	localparam int CntW = $clog2(NumW + 1);

	logic [NumW-1:0] q_q;
	logic [DenW:0]   r_q;
	logic [DenW-1:0] d_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic [DenW:0]   shifted;
	logic [DenW:0]   diff;

	assign shifted = {r_q[DenW-1:0], q_q[NumW-1]};
	assign diff = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CntW'(NumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (!diff[DenW]) begin
				r_q <= diff;
				q_q <= {q_q[NumW-2:0], 1'b1};
			end else begin
				r_q <= shifted;
				q_q <= {q_q[NumW-2:0], 1'b0};
			end
		end
	end

	assign quo = q_q;
endmodule

/* design/lccc_fit.sv */
// ----------------------------------------------------------------------------
// lccc_fit
// Three-point circle fit: a sequencer around one shared 34x34 multiplier
// and one serial divider; rounds, saturates and applies the depth test.
// ----------------------------------------------------------------------------
module lccc_fit
	import lccc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  point_t                 p1,
	input  point_t                 p2,
	input  point_t                 p3,
	input  logic [GapW-1:0]        depth_limit,
	output logic                   busy,
	output logic                   res_valid,
	output out_word_t              res
);
	localparam int MulW = 34;
	localparam int ProdW = 2 * MulW;
	localparam int NumW = 72;
	localparam int DenW = 40;

	typedef enum logic [3:0] {
		S_IDLE, S_DIFF, S_D1, S_D2, S_E1A, S_E1B, S_E2A, S_E2B,
		S_NX1, S_NX2, S_NY1, S_NY2, S_DIVX, S_DIVY, S_DONE
	} state_t;

	state_t state_q;
	logic signed [17:0] ax_q, ay_q, bx_q, by_q;
	logic signed [17:0] sx12_q, sy12_q, sx23_q, sy23_q;
	logic signed [MulW-1:0] e1_q, e2_q;
	logic signed [39:0] d_q;
	logic signed [NumW-1:0] acc_q;
	logic signed [NumW-1:0] nx_q;
	logic signed [CenterW-1:0] cx_q;
	logic signed [MulW-1:0] ma, mb;
	logic signed [ProdW-1:0] prod;
	logic div_start;
	logic div_done;
	logic [NumW-1:0] div_num;
	logic [DenW-1:0] div_den;
	logic [NumW-1:0] div_quo;
	logic signed [NumW-1:0] cur_num;
	logic neg;
	logic [NumW-1:0] unum;
	logic [DenW-1:0] uden;
	logic signed [CenterW-1:0] sat;

	assign prod = ma * mb;

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			S_D1: begin ma = MulW'(ax_q); mb = MulW'(by_q); end
			S_D2: begin ma = MulW'(ay_q); mb = MulW'(bx_q); end
			S_E1A: begin ma = MulW'(ax_q); mb = MulW'(sx12_q); end
			S_E1B: begin ma = MulW'(ay_q); mb = MulW'(sy12_q); end
			S_E2A: begin ma = MulW'(bx_q); mb = MulW'(sx23_q); end
			S_E2B: begin ma = MulW'(by_q); mb = MulW'(sy23_q); end
			S_NX1: begin ma = e1_q; mb = MulW'(by_q); end
			S_NX2: begin ma = MulW'(ay_q); mb = e2_q; end
			S_NY1: begin ma = MulW'(ax_q); mb = e2_q; end
			S_NY2: begin ma = e1_q; mb = MulW'(bx_q); end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	assign cur_num = (state_q == S_NY2) ? nx_q : acc_q;
	assign neg = ((state_q == S_DIVX) ? nx_q[NumW-1] : acc_q[NumW-1]) ^ d_q[39];
	assign unum = cur_num[NumW-1] ? NumW'(-cur_num) : NumW'(cur_num);
	assign uden = d_q[39] ? DenW'(-(d_q <<< 1)) : DenW'(d_q <<< 1);
	assign div_num = unum + NumW'(uden >> 1);
	assign div_den = uden;

	always_comb begin
		if (neg) begin
			sat = (div_quo > NumW'(24'h800000)) ? CenterMin
				: CenterW'(-$signed({1'b0, div_quo[CenterW-1:0]}));
		end else begin
			sat = (div_quo > NumW'(24'h7FFFFF)) ? CenterMax : CenterW'(div_quo);
		end
	end

	lccc_div #(.NumW(NumW), .DenW(DenW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .done(div_done), .quo(div_quo)
	);

	assign div_start = (state_q == S_NY2) || (state_q == S_DIVX && div_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_valid <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (start) state_q <= S_DIFF;
				S_DIFF: state_q <= (ay_q == 0 || by_q == 0) ? S_IDLE : S_D1;
				S_D1: state_q <= S_D2;
				S_D2: state_q <= S_E1A;
				S_E1A: state_q <= (d_q == 0) ? S_IDLE : S_E1B;
				S_E1B: state_q <= S_E2A;
				S_E2A: state_q <= S_E2B;
				S_E2B: state_q <= S_NX1;
				S_NX1: state_q <= S_NX2;
				S_NX2: state_q <= S_NY1;
				S_NY1: state_q <= S_NY2;
				S_NY2: state_q <= S_DIVX;
				S_DIVX: if (div_done) state_q <= S_DIVY;
				S_DIVY: if (div_done) state_q <= S_DONE;
				S_DONE: begin
					res_valid <= ($signed(sat) < -$signed({9'd0, depth_limit}));
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic signed [CenterW-1:0] cy_q;
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (start) begin
				ax_q <= 18'(p1.x) - 18'(p2.x);
				ay_q <= 18'(p1.y) - 18'(p2.y);
				bx_q <= 18'(p2.x) - 18'(p3.x);
				by_q <= 18'(p2.y) - 18'(p3.y);
				sx12_q <= 18'(p1.x) + 18'(p2.x);
				sy12_q <= 18'(p1.y) + 18'(p2.y);
				sx23_q <= 18'(p2.x) + 18'(p3.x);
				sy23_q <= 18'(p2.y) + 18'(p3.y);
			end
			S_D1: d_q <= 40'(prod);
			S_D2: d_q <= d_q - 40'(prod);
			S_E1A: e1_q <= MulW'(prod);
			S_E1B: e1_q <= e1_q + MulW'(prod);
			S_E2A: e2_q <= MulW'(prod);
			S_E2B: e2_q <= e2_q + MulW'(prod);
			S_NX1: acc_q <= NumW'(prod);
			S_NX2: acc_q <= acc_q - NumW'(prod);
			S_NY1: begin nx_q <= acc_q; acc_q <= NumW'(prod); end
			S_NY2: acc_q <= acc_q - NumW'(prod);
			S_DIVX: if (div_done) cx_q <= sat;
			S_DIVY: if (div_done) cy_q <= sat;
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE) || start;
	assign res.center_x = cx_q;
	assign res.center_y = (state_q == S_DONE) ? sat : cy_q;
endmodule

/* design/lidar_cluster_circle_center_top.sv */
// ----------------------------------------------------------------------------
// lidar_cluster_circle_center_top
// Lidar breakpoint segmentation with a three-point circle fit.
// ----------------------------------------------------------------------------
// Points arrive on pt_in (valid/ready); fitted centres leave on ctr_out.
// Configuration: cfg_we, cfg_idx, cfg_wdata, taken at any edge with cfg_we.
// A point that does not close a qualifying run is taken while the block stays
// in S_IN, so such points can follow back to back while no centre waits.
// A point that closes a qualifying run starts a fit: a store read, a
// difference step, the shared-multiplier steps, two serial divisions and a
// depth test, in that order. A fit with a flat pair ends at the difference
// step, a collinear one once the determinant is known. pt_in.ready is low
// meanwhile.
// A centre waits in an output register; while it is not taken, pt_in.ready
// stays low.
// Reset clears run state and loads the default registers; the run store
// needs no clearing.
// ----------------------------------------------------------------------------
module lidar_cluster_circle_center_top
	import lccc_pkg::*;
#(
	parameter int MAX_SCAN = 1024,
	parameter int RUN_STORE_DEPTH = 512
) (
	input  logic                 clk,
	input  logic                 arst_n,
	lccc_if.sink                 pt_in,
	lccc_if.source               ctr_out,
	input  logic                 cfg_we,
	input  logic [CfgAddrW-1:0]  cfg_idx,
	input  logic [CfgDataW-1:0]  cfg_wdata
);
	localparam int AddrW = $clog2(RUN_STORE_DEPTH);
	localparam int CntW = $clog2(MAX_SCAN + 1);

	typedef enum logic [1:0] {S_IN, S_RD, S_FIT} state_t;

	state_t state_q;
	logic [GapW-1:0] gap_q;
	logic [MinW-1:0] min_q;
	logic [GapW-1:0] depth_q;
	logic run_open_q;
	logic [CntW-1:0] cnt_q;
	point_t prev_q;
	point_t first_q;
	point_t cur_q;
	logic new_run_q;
	logic fit_go;
	logic fit_busy;
	logic fit_valid;
	out_word_t fit_res;
	logic ram_we;
	logic [AddrW-1:0] ram_addr;
	point_t ram_rd;
	point_t pin;
	logic signed [16:0] dx, dy;
	logic [16:0] adx, ady;
	logic brk, ready_run;
	logic [MinW-1:0] need;
	logic [CntW-1:0] mid;
	logic accept;

	assign pin.x = pt_in.data.point_x;
	assign pin.y = pt_in.data.point_y;
	assign dx = 17'(pin.x) - 17'(prev_q.x);
	assign dy = 17'(pin.y) - 17'(prev_q.y);
	assign adx = dx[16] ? 17'(-dx) : 17'(dx);
	assign ady = dy[16] ? 17'(-dy) : 17'(dy);
	assign brk = pt_in.data.scan_end || !run_open_q ||
		adx > 17'(gap_q) || ady > 17'(gap_q);
	assign need = (min_q == '0) ? MinW'(1) : min_q;
	assign ready_run = run_open_q && (CntW + 1)'(cnt_q) >= (CntW + 1)'(need);
	assign mid = cnt_q >> 1;
	assign accept = pt_in.valid && pt_in.ready;

	assign pt_in.ready = (state_q == S_IN) && !ctr_out.valid;

	always_comb begin
		ram_we = 1'b0;
		ram_addr = '0;
		if (accept && !pt_in.data.scan_end) begin
			if (brk && !(run_open_q && ready_run)) begin
				ram_we = 1'b1;
			end else if (!brk && cnt_q < CntW'(MAX_SCAN) &&
				32'(cnt_q) < 32'(RUN_STORE_DEPTH)) begin
				ram_we = 1'b1;
				ram_addr = AddrW'(cnt_q);
			end
		end
		if (accept && brk && ready_run) begin
			ram_addr = (32'(mid) >= 32'(RUN_STORE_DEPTH)) ?
				AddrW'(RUN_STORE_DEPTH - 1) : AddrW'(mid);
		end
	end

	lccc_ram #(.Width(2 * CoordW), .Depth(RUN_STORE_DEPTH)) u_store (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(pin), .rdata(ram_rd)
	);

	lccc_fit u_fit (
		.clk(clk), .arst_n(arst_n), .start(fit_go), .p1(first_q),
		.p2(ram_rd), .p3(prev_q), .depth_limit(depth_q), .busy(fit_busy),
		.res_valid(fit_valid), .res(fit_res)
	);

	assign fit_go = (state_q == S_RD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IN;
			gap_q <= GapW'(41);
			min_q <= MinW'(10);
			depth_q <= GapW'(123);
			run_open_q <= 1'b0;
			cnt_q <= '0;
			prev_q <= '0;
			first_q <= '0;
			cur_q <= '0;
			new_run_q <= 1'b0;
			ctr_out.valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_CLUSTER_GAP: gap_q <= cfg_wdata;
					REG_MIN_POINTS: min_q <= cfg_wdata[MinW-1:0];
					REG_DEPTH_LIMIT: depth_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (ctr_out.valid && ctr_out.ready) ctr_out.valid <= 1'b0;
			case (state_q)
				S_IN: if (accept) begin
					if (brk && ready_run) begin
						state_q <= S_RD;
						cur_q <= pin;
						new_run_q <= !pt_in.data.scan_end;
						run_open_q <= 1'b0;
						cnt_q <= '0;
					end else if (pt_in.data.scan_end) begin
						run_open_q <= 1'b0;
						cnt_q <= '0;
					end else if (brk) begin
						run_open_q <= 1'b1;
						cnt_q <= CntW'(1);
						first_q <= pin;
						prev_q <= pin;
					end else begin
						if (cnt_q < CntW'(MAX_SCAN)) cnt_q <= cnt_q + 1'b1;
						prev_q <= pin;
					end
				end
				S_RD: state_q <= S_FIT;
				S_FIT: if (!fit_busy) begin
					state_q <= S_IN;
					if (new_run_q) begin
						run_open_q <= 1'b1;
						cnt_q <= CntW'(1);
						first_q <= cur_q;
						prev_q <= cur_q;
						new_run_q <= 1'b0;
					end
				end
				default: state_q <= S_IN;
			endcase
			if (fit_valid) ctr_out.valid <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fit_valid) ctr_out.data <= fit_res;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IN) |-> !pt_in.ready)
		else $error("ready high during fit");
	assert property (@(posedge clk) disable iff (!arst_n)
		fit_valid |-> !ctr_out.valid)
		else $error("result overwritten");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |=> (state_q == S_FIT))
		else $error("read step skipped");
	assert property (@(posedge clk) disable iff (!arst_n)
		run_open_q |-> (cnt_q != '0))
		else $error("open run with zero count");
endmodule

/* dv/tb_lidar_cluster_circle_center_top.sv */
// ----------------------------------------------------------------------------
// tb_lidar_cluster_circle_center_top
// Self-checking bench for the lidar run segmenter and circle-center fitter.
// ----------------------------------------------------------------------------
// Points are fed in scan order, both as shaped runs (bounded steps, closed by
// a jump or an end-of-scan word) and as full-range noise. A behavioral copy of
// the segmenter and three-point fit predicts every reported center, and each
// center word leaving the block is compared field by field with the oldest
// prediction. Both sides idle at random; one phase holds the output off for a
// long stretch so that the block fills and stalls its input.
// ----------------------------------------------------------------------------
module tb_lidar_cluster_circle_center_top
	import lccc_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_SCAN = 1024;
	localparam int RUN_STORE_DEPTH = 512;
	localparam int ITEMS = 1800;
	localparam int SETTLE = 300;
	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 1500;
	localparam logic [CfgAddrW-1:0] REG_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CfgAddrW-1:0] cfg_idx;
	logic [CfgDataW-1:0] cfg_wdata;

	lccc_if #(.T(in_word_t)) pt_if ();
	lccc_if #(.T(out_word_t)) ctr_if ();

	lidar_cluster_circle_center_top #(
		.MAX_SCAN(MAX_SCAN),
		.RUN_STORE_DEPTH(RUN_STORE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pt_in(pt_if),
		.ctr_out(ctr_if),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// shadow of the block
	int unsigned gap_reg;
	int unsigned min_reg;
	int unsigned depth_reg;
	bit run_open;
	int run_count;
	point_t last_pt;
	point_t run_pts[RUN_STORE_DEPTH];
	out_word_t centers_due[$];

	int errors;
	int sent;
	int idle_cycles;
	int hold_req;
	bit brisk;
	point_t walk;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report(string what);
		$display("MISMATCH @%0t: %s", $realtime, what);
		errors++;
	endtask

	function automatic longint round_div(longint num, longint den);
		longint un;
		longint ud;
		longint q;
		un = num < 0 ? -num : num;
		ud = den < 0 ? -den : den;
		q = (un + ud / 2) / ud;
		if ((num < 0) != (den < 0)) begin
			if (q > 8388608) q = 8388608;
			return -q;
		end
		if (q > 8388607) q = 8388607;
		return q;
	endfunction

	function automatic bit fit_center(output out_word_t c);
		int mid;
		longint x1, y1, x2, y2, x3, y3, ax, ay, bx, by, d, e1, e2, cx, cy;
		mid = run_count / 2;
		if (mid >= RUN_STORE_DEPTH) mid = RUN_STORE_DEPTH - 1;
		x1 = run_pts[0].x; y1 = run_pts[0].y;
		x2 = run_pts[mid].x; y2 = run_pts[mid].y;
		x3 = last_pt.x; y3 = last_pt.y;
		ax = x1 - x2; ay = y1 - y2;
		bx = x2 - x3; by = y2 - y3;
		c = '0;
		if (ay == 0 || by == 0) return 1'b0;
		d = ax * by - ay * bx;
		if (d == 0) return 1'b0;
		e1 = ax * (x1 + x2) + ay * (y1 + y2);
		e2 = bx * (x2 + x3) + by * (y2 + y3);
		cx = round_div(e1 * by - ay * e2, 2 * d);
		cy = round_div(ax * e2 - e1 * bx, 2 * d);
		if (!(cy < -longint'(depth_reg))) return 1'b0;
		c.center_x = cx[CenterW-1:0];
		c.center_y = cy[CenterW-1:0];
		return 1'b1;
	endfunction

	function automatic void close_run();
		out_word_t c;
		int unsigned need;
		need = (min_reg == 0) ? 1 : min_reg;
		if (run_open && run_count >= need)
			if (fit_center(c)) centers_due = {centers_due, c};
	endfunction

	function automatic void track_point(in_word_t w);
		point_t p;
		int dx;
		int dy;
		p.x = w.point_x;
		p.y = w.point_y;
		if (w.scan_end) begin
			close_run();
			run_open = 1'b0;
			run_count = 0;
			return;
		end
		if (run_open) begin
			dx = int'(p.x) - int'(last_pt.x);
			dy = int'(p.y) - int'(last_pt.y);
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			if (dx > int'(gap_reg) || dy > int'(gap_reg)) begin
				close_run();
				run_open = 1'b0;
			end else begin
				if (run_count < MAX_SCAN) begin
					if (run_count < RUN_STORE_DEPTH) run_pts[run_count] = p;
					run_count++;
				end
				last_pt = p;
			end
		end
		if (!run_open) begin
			run_pts[0] = p;
			run_count = 1;
			last_pt = p;
			run_open = 1'b1;
		end
	endfunction

	function automatic logic signed [CoordW-1:0] clamp16(int v);
		if (v > 32767) return 16'sh7FFF;
		if (v < -32768) return -16'sh8000;
		return v[CoordW-1:0];
	endfunction

	// input monitor drives the prediction
	always @(posedge clk) begin
		if (pt_if.valid && pt_if.ready) track_point(pt_if.data);
	end

	// result checker
	always @(posedge clk) begin
		out_word_t want;
		if (ctr_if.valid && ctr_if.ready) begin
			if (centers_due.size() == 0) begin
				report($sformatf("unexpected center (%0d, %0d)",
					ctr_if.data.center_x, ctr_if.data.center_y));
			end else begin
				want = centers_due.pop_front();
				if (ctr_if.data.center_x !== want.center_x)
					report($sformatf("center_x got %0d want %0d",
						ctr_if.data.center_x, want.center_x));
				if (ctr_if.data.center_y !== want.center_y)
					report($sformatf("center_y got %0d want %0d",
						ctr_if.data.center_y, want.center_y));
			end
		end
	end

	always @(posedge clk) begin
		if ((pt_if.valid && pt_if.ready) || (ctr_if.valid && ctr_if.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// center receiver: random stalls, plus a long hold when requested
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = brisk ? 0 : $urandom_range(0, 4);
			if (hold_req > 0) begin
				n = hold_req;
				hold_req = 0;
			end
			if (n > 0) begin
				ctr_if.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			ctr_if.ready <= 1'b1;
			do @(posedge clk); while (!ctr_if.valid);
		end
	end

	task automatic send_point(logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y,
			bit last);
		int n;
		n = brisk ? 0 : $urandom_range(0, 4);
		if (n > 0) begin
			pt_if.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		pt_if.valid <= 1'b1;
		pt_if.data <= '{point_x: x, point_y: y, scan_end: last};
		do @(posedge clk); while (!pt_if.ready);
		walk.x = x;
		walk.y = y;
		sent++;
	endtask

	task automatic drain();
		pt_if.valid <= 1'b0;
		while (centers_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CfgAddrW-1:0] idx, int unsigned val);
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val[CfgDataW-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CLUSTER_GAP: gap_reg = val & 32'h7FFF;
			REG_MIN_POINTS: min_reg = val & 32'h7FF;
			REG_DEPTH_LIMIT: depth_reg = val & 32'h7FFF;
			default: ;
		endcase
	endtask

	task automatic configure(int unsigned g, int unsigned m, int unsigned d);
		write_reg(REG_CLUSTER_GAP, g);
		write_reg(REG_MIN_POINTS, m);
		write_reg(REG_DEPTH_LIMIT, d);
	endtask

	// walk len points with steps inside the gap, then close by jump or end word
	task automatic send_run(int len, bit by_end);
		int g;
		int sx;
		int sy;
		g = (gap_reg > 4000) ? 4000 : gap_reg;
		if ($urandom_range(0, 3) == 0) g = gap_reg;
		send_point(16'($urandom), 16'($urandom), 1'b0);
		for (int k = 1; k < len; k++) begin
			sx = int'($urandom_range(0, 2 * g)) - g;
			sy = int'($urandom_range(0, 2 * g)) - g;
			send_point(clamp16(int'(walk.x) + sx), clamp16(int'(walk.y) + sy), 1'b0);
		end
		if (by_end) begin
			send_point(16'($urandom), 16'($urandom), 1'b1);
		end else begin
			sx = (walk.x >= 0) ? int'(walk.x) - int'(gap_reg) - 1
				: int'(walk.x) + int'(gap_reg) + 1;
			send_point(sx[CoordW-1:0], 16'($urandom), 1'b0);
		end
	endtask

	task automatic test_directed();
		send_point(16'sd0, 16'sd0, 1'b1);
		configure(32767, 3, 0);
		send_point(-16'sd4096, -16'sd8192, 1'b0);
		send_point(16'sd0, -16'sd4096, 1'b0);
		send_point(16'sd2896, -16'sd5296, 1'b0);
		send_point(16'sd0, 16'sd0, 1'b1);
		// nearly collinear, both bends: only the second forms a full run, and its center_y saturates
		send_point(16'sd0, 16'sd0, 1'b0);
		send_point(16'sd16384, 16'sd1, 1'b0);
		send_point(16'sd32767, 16'sd3, 1'b1);
		send_point(16'sd0, 16'sd0, 1'b0);
		send_point(16'sd16384, -16'sd1, 1'b0);
		send_point(16'sd32767, -16'sd3, 1'b0);
		send_point(16'sd0, 16'sd0, 1'b1);
		// equal y and collinear triples
		send_point(16'sd100, 16'sd50, 1'b0);
		send_point(16'sd200, 16'sd50, 1'b0);
		send_point(16'sd300, 16'sd90, 1'b0);
		send_point(16'sd0, 16'sd0, 1'b1);
		send_point(16'sd10, 16'sd10, 1'b0);
		send_point(16'sd20, 16'sd20, 1'b0);
		send_point(16'sd30, 16'sd30, 1'b1);
		// field extremes with a zero gap
		configure(0, 0, 32767);
		send_point(-16'sh8000, -16'sh8000, 1'b0);
		send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
		send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
		send_point(-16'sh8000, 16'sh7FFF, 1'b1);
		write_reg(REG_UNUSED, 32'h7FFF);
		write_reg(REG_MIN_POINTS, 32'h7FFF);
		send_run(5, 1'b1);
	endtask

	task automatic test_long_runs();
		configure(32767, 1024, 0);
		send_run(1030, 1'b1);
		configure(2000, 30, 0);
		send_run(60, 1'b0);
	endtask

	task automatic test_backpressure();
		configure(32767, 3, 0);
		hold_req = HOLD_CYCLES;
		for (int r = 0; r < 30; r++) send_run($urandom_range(3, 6), r[0]);
	endtask

	task automatic test_random();
		int runs;
		runs = 0;
		while (sent < ITEMS) begin
			if (runs % 25 == 0) begin
				case ($urandom_range(0, 3))
					0: configure(41, 10, 123);
					1: configure(32767, $urandom_range(1, 4), 0);
					2: configure($urandom_range(0, 32767), $urandom_range(0, 12),
						$urandom_range(0, 8192));
					default: configure($urandom_range(8, 3000), $urandom_range(2, 8),
						$urandom_range(0, 500));
				endcase
				brisk = ($urandom_range(0, 2) == 0);
			end
			if ($urandom_range(0, 4) == 0)
				send_point(16'($urandom), 16'($urandom), $urandom_range(0, 1));
			else
				send_run($urandom_range(1, 24), $urandom_range(0, 1));
			runs++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		pt_if.valid = 1'b0;
		pt_if.data = '0;
		ctr_if.ready = 1'b0;
		gap_reg = 41;
		min_reg = 10;
		depth_reg = 123;
		run_open = 1'b0;
		run_count = 0;
		last_pt = '0;
		errors = 0;
		sent = 0;
		idle_cycles = 0;
		hold_req = 0;
		brisk = 1'b0;
		walk = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_long_runs();
		test_backpressure();
		test_random();
		drain();
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
